@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS   = 16;
  // one restoring step per numerator bit: 32 integer bits plus 2*FRAC_BITS
  localparam int DIV_STEPS   = 32 + 2 * FRAC_BITS;
  localparam int QW          = DIV_STEPS;
  // one step per result bit of a 64-bit radicand
  localparam int SQRT_STEPS  = 32;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_CONJ  = 3'd4,
    CMD_NEG   = 3'd5,
    CMD_RECIP = 3'd6,
    CMD_MOD   = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic        neg_re;
    logic        neg_im;
    logic        d_zero;
  } item_t;

  typedef struct packed {
    item_t         item;
    logic [63:0]   d;
    logic [31:0]   m_re;
    logic [31:0]   m_im;
    logic [63:0]   r_re;
    logic [63:0]   r_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [63:0]   n;
    logic [63:0]   root;
  } dstage_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

endpackage

@@ hw/rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// Input register, squares of the norm operand and the squared norm.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               v_out,
  output dstage_t            st_out
);

  logic               v0, v1, v2;
  item_t              it0, it1, it2;
  item_t              it1_next, it2_next;
  logic signed [31:0] xr, xi;
  logic signed [63:0] sq_re, sq_im;
  logic [31:0]        m_re1, m_im1, m_re2, m_im2;
  logic [63:0]        d2;
  logic [63:0]        d_next;

  // divide takes the norm of b, reciprocal and modulus that of a
  assign xr = (it0.cmd == CMD_DIV) ? $signed(it0.b_re) : $signed(it0.a_re);
  assign xi = (it0.cmd == CMD_DIV) ? $signed(it0.b_im) : $signed(it0.a_im);
  assign d_next = $unsigned(sq_re) + $unsigned(sq_im);

  always_comb begin
    it1_next        = it0;
    it1_next.neg_re = xr[31];
    it1_next.neg_im = xi[31];
    it2_next        = it1;
    it2_next.d_zero = (d_next == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0.cmd    <= cmd_t'(command);
      it0.a_re   <= a_re;
      it0.a_im   <= a_im;
      it0.b_re   <= b_re;
      it0.b_im   <= b_im;
      it0.neg_re <= 1'b0;
      it0.neg_im <= 1'b0;
      it0.d_zero <= 1'b0;

      it1        <= it1_next;
      sq_re      <= xr * xr;
      sq_im      <= xi * xi;
      m_re1      <= xr[31] ? 32'(-xr) : xr;
      m_im1      <= xi[31] ? 32'(-xi) : xi;

      it2        <= it2_next;
      d2         <= d_next;
      m_re2      <= m_re1;
      m_im2      <= m_im1;
    end
  end

  assign v_out = v2;

  always_comb begin
    st_out      = '0;
    st_out.item = it2;
    st_out.d    = d2;
    st_out.m_re = m_re2;
    st_out.m_im = m_im2;
    st_out.n    = d2;
  end

endmodule

@@ hw/rtl/cau_divsqrt.sv @@
// ----------------------------------------------------------------------------
// cau_divsqrt
// Pipelined restoring divider (two lanes sharing one divisor) with a
// digit-by-digit square root running in the first stages.
// ----------------------------------------------------------------------------
module cau_divsqrt import cau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    v_in,
  input  dstage_t st_in,
  output logic    v_out,
  output dstage_t st_out
);

  logic    vld [0:DIV_STEPS];
  dstage_t st  [0:DIV_STEPS];

  assign vld[0] = v_in;
  assign st[0]  = st_in;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic        bre, bim;
    logic [64:0] t_re, t_im, s_re, s_im;
    logic        ge_re, ge_im;
    logic [63:0] n_nx, root_nx;
    dstage_t     nx;

    // numerator bits come from the magnitude, then fractional zeros
    if (k < 32) begin : g_bit
      assign bre = st[k].m_re[31-k];
      assign bim = st[k].m_im[31-k];
    end else begin : g_zero
      assign bre = 1'b0;
      assign bim = 1'b0;
    end

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      assign trial = st[k].root + SQ_BIT;
      always_comb begin
        if (st[k].n >= trial) begin
          n_nx    = st[k].n - trial;
          root_nx = (st[k].root >> 1) + SQ_BIT;
        end else begin
          n_nx    = st[k].n;
          root_nx = st[k].root >> 1;
        end
      end
    end else begin : g_hold
      assign n_nx    = st[k].n;
      assign root_nx = st[k].root;
    end

    assign t_re  = {st[k].r_re, bre};
    assign t_im  = {st[k].r_im, bim};
    assign s_re  = t_re - {1'b0, st[k].d};
    assign s_im  = t_im - {1'b0, st[k].d};
    assign ge_re = ~s_re[64];
    assign ge_im = ~s_im[64];

    always_comb begin
      nx      = st[k];
      nx.r_re = ge_re ? s_re[63:0] : t_re[63:0];
      nx.r_im = ge_im ? s_im[63:0] : t_im[63:0];
      nx.q_re = {st[k].q_re[QW-2:0], ge_re};
      nx.q_im = {st[k].q_im[QW-2:0], ge_im};
      nx.n    = n_nx;
      nx.root = root_nx;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nx;
      end
    end
  end

  assign v_out  = vld[DIV_STEPS];
  assign st_out = st[DIV_STEPS];

endmodule

@@ hw/rtl/cau_back.sv @@
// ----------------------------------------------------------------------------
// cau_back
// Reciprocal sign and saturation, complex products, result select and the
// output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  dstage_t            st_in,
  output logic               out_valid,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               div_zero,
  output logic               overflow
);

  localparam logic signed [64:0] MAX65 = 65'sd2147483647;
  localparam logic signed [64:0] MIN65 = -65'sd2147483648;

  function automatic sat_t sign_sat(input logic [QW-1:0] q, input logic neg);
    sat_t s;
    if (neg) begin
      if (q > QW'(32'h80000000)) s = '{val: 32'h80000000, ov: 1'b1};
      else                       s = '{val: ~q[31:0] + 32'd1, ov: 1'b0};
    end else begin
      if (q > QW'(32'h7fffffff)) s = '{val: 32'h7fffffff, ov: 1'b1};
      else                       s = '{val: q[31:0], ov: 1'b0};
    end
    return s;
  endfunction

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t s;
    if (v > MAX65)      s = '{val: 32'h7fffffff, ov: 1'b1};
    else if (v < MIN65) s = '{val: 32'h80000000, ov: 1'b1};
    else                s = '{val: v[31:0], ov: 1'b0};
    return s;
  endfunction

  logic               v1, v2;
  item_t              it1, it2;
  logic [31:0]        y_re1, y_im1, y_re2, y_im2;
  logic               rec_ov1, rec_ov2, root_ov1, root_ov2;
  logic [31:0]        root1, root2;
  logic signed [63:0] p1, p2, p3, p4;
  sat_t               rec_re, rec_im;
  logic               use_rec;

  assign rec_re  = sign_sat(st_in.q_re, st_in.item.neg_re);
  assign rec_im  = sign_sat(st_in.q_im, ~st_in.item.neg_im);
  assign use_rec = (st_in.item.cmd == CMD_DIV) || (st_in.item.cmd == CMD_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= v_in;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1      <= st_in.item;
      y_re1    <= use_rec ? rec_re.val : st_in.item.b_re;
      y_im1    <= use_rec ? rec_im.val : st_in.item.b_im;
      rec_ov1  <= rec_re.ov | rec_im.ov;
      root_ov1 <= (st_in.root > 64'd2147483647);
      root1    <= (st_in.root > 64'd2147483647) ? 32'h7fffffff : st_in.root[31:0];

      it2      <= it1;
      y_re2    <= y_re1;
      y_im2    <= y_im1;
      rec_ov2  <= rec_ov1;
      root_ov2 <= root_ov1;
      root2    <= root1;
      p1       <= $signed(it1.a_re) * $signed(y_re1);
      p2       <= $signed(it1.a_im) * $signed(y_im1);
      p3       <= $signed(it1.a_re) * $signed(y_im1);
      p4       <= $signed(y_re1) * $signed(it1.a_im);
    end
  end

  logic signed [64:0] ar, ai, br, bi, sum_re, sum_im;
  sat_t               m_re, m_im, s0, s1;
  logic [31:0]        rr_next, ri_next;
  logic               ov_next, dz_next;

  always_comb begin
    ar     = 65'($signed(it2.a_re));
    ai     = 65'($signed(it2.a_im));
    br     = 65'($signed(it2.b_re));
    bi     = 65'($signed(it2.b_im));
    sum_re = (65'(p1) - 65'(p2)) >>> FRAC_BITS;
    sum_im = (65'(p3) + 65'(p4)) >>> FRAC_BITS;
    m_re   = sat32(sum_re);
    m_im   = sat32(sum_im);
    s0     = '0;
    s1     = '0;
    dz_next = 1'b0;
    unique case (it2.cmd)
      CMD_ADD: begin
        s0 = sat32(ar + br);
        s1 = sat32(ai + bi);
        rr_next = s0.val; ri_next = s1.val; ov_next = s0.ov | s1.ov;
      end
      CMD_SUB: begin
        s0 = sat32(ar - br);
        s1 = sat32(ai - bi);
        rr_next = s0.val; ri_next = s1.val; ov_next = s0.ov | s1.ov;
      end
      CMD_MUL: begin
        rr_next = m_re.val; ri_next = m_im.val; ov_next = m_re.ov | m_im.ov;
      end
      CMD_DIV: begin
        rr_next = m_re.val; ri_next = m_im.val;
        ov_next = m_re.ov | m_im.ov | rec_ov2;
        dz_next = it2.d_zero;
      end
      CMD_CONJ: begin
        s1 = sat32(-ai);
        rr_next = it2.a_re; ri_next = s1.val; ov_next = s1.ov;
      end
      CMD_NEG: begin
        s0 = sat32(-ar);
        s1 = sat32(-ai);
        rr_next = s0.val; ri_next = s1.val; ov_next = s0.ov | s1.ov;
      end
      CMD_RECIP: begin
        rr_next = y_re2; ri_next = y_im2; ov_next = rec_ov2;
        dz_next = it2.d_zero;
      end
      CMD_MOD: begin
        rr_next = root2; ri_next = 32'd0; ov_next = root_ov2;
      end
      default: begin
        rr_next = 32'd0; ri_next = 32'd0; ov_next = 1'b0;
      end
    endcase
    // zero divisor: drop the result and the overflow
    if (dz_next) begin
      rr_next = 32'd0;
      ri_next = 32'd0;
      ov_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re   <= rr_next;
      res_im   <= ri_next;
      div_zero <= dz_next;
      overflow <= ov_next;
    end
  end

endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, sub, mul, div, conjugate, negate, reciprocal and modulus in
// signed fixed point with FRAC_BITS fractional bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with command, a_re, a_im, b_re, b_im.
//   A request is taken at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with res_re, res_im, div_zero and
//   overflow; a result is taken when out_valid is high and out_stall low.
//   Every command runs through the same pipeline, so results leave in order.
//   The pipeline has three front stages (input register, squares, norm),
//   one restoring divider step per stage over 32 + 2*FRAC_BITS stages, and
//   three back stages.
//   Throughput is one request per cycle while no result is held by out_stall.
//   When the receiver holds out_stall with a result waiting, the whole
//   pipeline freezes and in_stall rises in the same cycle; nothing is lost.
//   Synchronous reset clears all valid bits; the pipeline is empty after it.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               div_zero,
  output logic               overflow
);

  logic    en;
  logic    v_front, v_div;
  dstage_t st_front, st_div;

  // advance unless a finished result is held back
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .command  (command),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .v_out    (v_front),
    .st_out   (st_front)
  );

  cau_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .v_in   (v_front),
    .st_in  (st_front),
    .v_out  (v_div),
    .st_out (st_div)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_in      (v_div),
    .st_in     (st_div),
    .out_valid (out_valid),
    .res_re    (res_re),
    .res_im    (res_im),
    .div_zero  (div_zero),
    .overflow  (overflow)
  );

endmodule

@@ sim/cau_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_checker
// Watches both channels of the complex arithmetic unit, predicts each result
// from the accepted request in fixed point and compares every field in order.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] res_re,
  input  logic signed [31:0] res_im,
  input  logic               div_zero,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ov;
  } cres_t;

  localparam logic signed [127:0] LIM_HI = 128'sd2147483647;
  localparam logic signed [127:0] LIM_LO = -128'sd2147483648;

  cres_t expected_q[$];

  function automatic logic signed [127:0] clamp32(input logic signed [127:0] v,
                                                  inout logic ov);
    if (v > LIM_HI) begin
      ov = 1'b1;
      return LIM_HI;
    end
    if (v < LIM_LO) begin
      ov = 1'b1;
      return LIM_LO;
    end
    return v;
  endfunction

  // floor of (x*y - or + u*w) >> FRAC_BITS, exact in 128 bits
  function automatic logic signed [127:0] mac_shift(input logic signed [127:0] s,
                                                    inout logic ov);
    return clamp32(s >>> FRAC_BITS, ov);
  endfunction

  // floor(m * 2^(2F) / d), capped just above 2^33
  function automatic logic signed [127:0] scaled_quot(input logic [127:0] m,
                                                      input logic [127:0] d);
    logic [127:0] q;
    q = (m << (2 * FRAC_BITS)) / d;
    if (q > (128'd1 << 33)) q = (128'd1 << 33) + 1;
    return $signed(q);
  endfunction

  function automatic logic recip_of(input logic signed [127:0] xr,
                                    input logic signed [127:0] xi,
                                    output logic signed [127:0] rr,
                                    output logic signed [127:0] ri,
                                    inout logic ov);
    logic [127:0] d;
    logic signed [127:0] qr, qi;
    d = xr * xr + xi * xi;
    rr = 0;
    ri = 0;
    if (d == 0) return 1'b0;
    qr = scaled_quot(xr < 0 ? -xr : xr, d);
    qi = scaled_quot(xi < 0 ? -xi : xi, d);
    rr = clamp32(xr < 0 ? -qr : qr, ov);
    ri = clamp32(xi < 0 ? qi : -qi, ov);
    return 1'b1;
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r;
    r = 0;
    for (int i = 33; i >= 0; i--)
      if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= n) r = r | (128'd1 << i);
    return r;
  endfunction

  function automatic cres_t predict_result(input cmd_t op,
                                           input logic signed [31:0] xr32,
                                           input logic signed [31:0] xi32,
                                           input logic signed [31:0] yr32,
                                           input logic signed [31:0] yi32);
    logic signed [127:0] xr, xi, yr, yi, rr, ri, tr, ti;
    logic [127:0] root;
    logic ov, dz;
    cres_t r;
    xr = xr32;
    xi = xi32;
    yr = yr32;
    yi = yi32;
    rr = 0;
    ri = 0;
    ov = 1'b0;
    dz = 1'b0;
    case (op)
      CMD_ADD: begin
        rr = clamp32(xr + yr, ov);
        ri = clamp32(xi + yi, ov);
      end
      CMD_SUB: begin
        rr = clamp32(xr - yr, ov);
        ri = clamp32(xi - yi, ov);
      end
      CMD_MUL: begin
        rr = mac_shift(xr * yr - xi * yi, ov);
        ri = mac_shift(xr * yi + yr * xi, ov);
      end
      CMD_DIV: begin
        if (recip_of(yr, yi, tr, ti, ov)) begin
          rr = mac_shift(xr * tr - xi * ti, ov);
          ri = mac_shift(xr * ti + tr * xi, ov);
        end else dz = 1'b1;
      end
      CMD_CONJ: begin
        rr = xr;
        ri = clamp32(-xi, ov);
      end
      CMD_NEG: begin
        rr = clamp32(-xr, ov);
        ri = clamp32(-xi, ov);
      end
      CMD_RECIP: begin
        if (!recip_of(xr, xi, rr, ri, ov)) dz = 1'b1;
      end
      default: begin
        root = floor_sqrt(xr * xr + xi * xi);
        if (root > 128'd2147483647) begin
          ov = 1'b1;
          root = 128'd2147483647;
        end
        rr = $signed(root);
        ri = 0;
      end
    endcase
    if (dz) begin
      rr = 0;
      ri = 0;
      ov = 1'b0;
    end
    r.re = rr[31:0];
    r.im = ri[31:0];
    r.dz = dz;
    r.ov = ov;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    cres_t e;
    if (rst) begin
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_result(cmd_t'(command), a_re, a_im, b_re, b_im));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result re=%h im=%h", res_re, res_im);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.re !== res_re || e.im !== res_im || e.dz !== div_zero ||
              e.ov !== overflow) begin
            if (fail_count < 10)
              $display("mismatch exp re=%h im=%h dz=%b ov=%b got re=%h im=%h dz=%b ov=%b",
                       e.re, e.im, e.dz, e.ov, res_re, res_im, div_zero, overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/tb_complex_arithmetic_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives directed corner requests and random requests of every command into
// the complex arithmetic unit under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         command;
  logic signed [31:0] a_re, a_im, b_re, b_im;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] res_re, res_im;
  logic               div_zero, overflow;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  complex_arithmetic_unit dut (.*);

  cau_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] pick_part();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return $urandom_range(255) - 128;
      6: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input cmd_t op, input logic [31:0] xr, input logic [31:0] xi,
                              input logic [31:0] yr, input logic [31:0] yi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    a_re     <= xr;
    a_im     <= xi;
    b_re     <= yr;
    b_im     <= yi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n)
      send_request(cmd_t'($urandom_range(7)), pick_part(), pick_part(), pick_part(),
                   pick_part());
  endtask

  initial begin
    logic [31:0] ext[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff,
                            32'h0001_0000};
    in_valid = 1'b0;
    command = CMD_ADD;
    a_re = 0;
    a_im = 0;
    b_re = 0;
    b_im = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // corners: every command on extremes, zero divisors, most negative negate
    for (int c = 0; c < 8; c++)
      send_request(cmd_t'(c), ext[c % 5], ext[(c + 1) % 5], ext[(c + 3) % 5], ext[c % 5]);
    send_request(CMD_DIV, 32'h0001_0000, 32'h0, 32'd0, 32'd0);
    send_request(CMD_RECIP, 32'd0, 32'd0, 32'h7fff_ffff, 32'd1);
    send_request(CMD_NEG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_request(CMD_CONJ, 32'd5, 32'h8000_0000, 32'd0, 32'd0);
    send_request(CMD_MOD, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_request(CMD_RECIP, 32'd1, 32'd0, 32'd0, 32'd0);
    send_request(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd1);
    send_request(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_request(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
    send_request(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff);
    // hold until the pipeline drains
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    run_random(300, 0, 0);
    run_random(200, 85, 0);
    run_random(200, 0, 85);
    run_random(230, 12, 12);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
